### rtl/core/ssi_pkg.sv
package ssi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam longint unsigned RADIUS_RESET = 64'd65536;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_RADIUS
    } cfg_idx_t;

endpackage

### rtl/core/segment_sphere_intersection.sv
// channel   direction  transfer condition          payload
// command   in         start && !busy              start_x/y/z, end_x/y/z
// result    out        done (one cycle)            hit, hit_x/y/z, start_inside
// config    in         cfg_valid && cfg_ready      cfg_index, cfg_data
//
// fully pipelined: one segment per cycle
// the pipeline holds a square root (one root bit per stage) and a divider (one
// quotient bit per stage); busy and cfg_ready stay low and high
// rst_n clears valid bits and loads the register reset values
// the receiver cannot stall; a result is on the ports for the one cycle done is high
module segment_sphere_intersection #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] start_z,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] end_z,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] hit_x,
    output logic signed [COORD_WIDTH-1:0] hit_y,
    output logic signed [COORD_WIDTH-1:0] hit_z,
    output logic                          start_inside,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data
);

    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 1;
    localparam int SW  = 2 * W + 4;
    localparam int DW  = 2 * SW;
    localparam int RW  = DW / 2;
    localparam int NSW = SW + 2;
    localparam int NW  = SW + 1 + VW + 1;
    localparam int QB  = W + 2;

    typedef struct packed {
        logic                 vld;
        logic                 in_sph;
        logic                 ok;
        logic [SW-1:0]        a;
        logic [SW-1:0]        h;
        logic [2:0][W-1:0]    s;
        logic [2:0][VW-1:0]   v;
    } side_t;

    logic [W-1:0]   center_x_reg;
    logic [W-1:0]   center_y_reg;
    logic [W-1:0]   center_z_reg;
    logic [W-2:0]   radius_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= (W-1)'(ssi_pkg::RADIUS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ssi_pkg::cfg_idx_t'(cfg_index))
                ssi_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                ssi_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                ssi_pkg::CFG_CENTER_Z: center_z_reg <= cfg_data;
                ssi_pkg::CFG_RADIUS:   radius_reg   <= cfg_data[W-2:0];
            endcase
        end
    end

    // stage 1: direction and offset from center
    logic [2:0][W-1:0] s_in, e_in, c_in;
    side_t side1_c, side1_reg;
    logic [VW-1:0] d1_reg [3];
    logic [W-2:0]  r1_reg;

    assign s_in = {start_z, start_y, start_x};
    assign e_in = {end_z, end_y, end_x};
    assign c_in = {center_z_reg, center_y_reg, center_x_reg};

    always_comb
    begin
        side1_c        = '0;
        side1_c.vld    = start && !busy;
        side1_c.s      = s_in;
        for (int i = 0; i < 3; i++)
        begin
            side1_c.v[i] = $unsigned(VW'($signed(e_in[i])) - VW'($signed(s_in[i])));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side1_reg <= '0;
        else
            side1_reg <= side1_c;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i] <= $unsigned(VW'($signed(s_in[i])) - VW'($signed(c_in[i])));
        end
        r1_reg <= radius_reg;
    end

    // stages 2-3: dot product terms
    logic signed [2*VW-1:0] pvv [3];
    logic signed [2*VW-1:0] pvd [3];
    logic signed [2*VW-1:0] pdd [3];
    logic signed [2*W-1:0]  prr;

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_dot
        ssi_mul #(.AW(VW), .BW(VW)) u_vv (
            .clk (clk),
            .a   ($signed(side1_reg.v[gi])),
            .b   ($signed(side1_reg.v[gi])),
            .p   (pvv[gi])
        );
        ssi_mul #(.AW(VW), .BW(VW)) u_vd (
            .clk (clk),
            .a   ($signed(side1_reg.v[gi])),
            .b   ($signed(d1_reg[gi])),
            .p   (pvd[gi])
        );
        ssi_mul #(.AW(VW), .BW(VW)) u_dd (
            .clk (clk),
            .a   ($signed(d1_reg[gi])),
            .b   ($signed(d1_reg[gi])),
            .p   (pdd[gi])
        );
    end

    ssi_mul #(.AW(W), .BW(W)) u_rr (
        .clk (clk),
        .a   ($signed({1'b0, r1_reg})),
        .b   ($signed({1'b0, r1_reg})),
        .p   (prr)
    );

    side_t side2_reg, side3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side2_reg <= '0;
            side3_reg <= '0;
        end
        else
        begin
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
        end
    end

    // stage 4: a, h, c and the inside test
    logic signed [SW-1:0] a_c, h_c, dd_c, r2_c;
    side_t side4_c, side4_reg;
    logic [SW-1:0] c4_reg;

    always_comb
    begin
        a_c  = SW'(pvv[0]) + SW'(pvv[1]) + SW'(pvv[2]);
        h_c  = SW'(pvd[0]) + SW'(pvd[1]) + SW'(pvd[2]);
        dd_c = SW'(pdd[0]) + SW'(pdd[1]) + SW'(pdd[2]);
        r2_c = SW'(prr);
        side4_c        = side3_reg;
        side4_c.a      = $unsigned(a_c);
        side4_c.h      = $unsigned(h_c);
        side4_c.in_sph = dd_c < r2_c;
        side4_c.ok     = a_c != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side4_reg <= '0;
        else
            side4_reg <= side4_c;
    end

    always_ff @(posedge clk)
    begin
        c4_reg <= $unsigned(dd_c - r2_c);
    end

    // stages 5-6: discriminant products
    logic signed [DW-1:0] phh, pac;

    ssi_mul #(.AW(SW), .BW(SW)) u_hh (
        .clk (clk),
        .a   ($signed(side4_reg.h)),
        .b   ($signed(side4_reg.h)),
        .p   (phh)
    );

    ssi_mul #(.AW(SW), .BW(SW)) u_ac (
        .clk (clk),
        .a   ($signed(side4_reg.a)),
        .b   ($signed(c4_reg)),
        .p   (pac)
    );

    side_t side5_reg, side6_reg, side7_reg, side7_next;
    logic [DW-1:0] disc_c, disc7_reg;

    assign disc_c = $unsigned(phh - pac);

    always_comb
    begin
        side7_next    = side6_reg;
        side7_next.ok = side6_reg.ok && !disc_c[DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side5_reg <= '0;
            side6_reg <= '0;
            side7_reg <= '0;
        end
        else
        begin
            side5_reg <= side4_reg;
            side6_reg <= side5_reg;
            side7_reg <= side7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        disc7_reg <= disc_c;
    end

    // square root, one root bit per stage
    side_t         sq_reg  [RW];
    logic [DW-1:0] rem_reg [RW];
    logic [RW-1:0] q_reg   [RW];

    for (genvar gi = 0; gi < RW; gi++)
    begin : g_sqrt
        localparam int K = RW - 1 - gi;
        logic [DW-1:0] rem_in, trial;
        logic [RW-1:0] q_in;
        side_t         sd_in;

        if (gi == 0)
        begin : g_first
            assign rem_in = disc7_reg;
            assign q_in   = '0;
            assign sd_in  = side7_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[gi-1];
            assign q_in   = q_reg[gi-1];
            assign sd_in  = sq_reg[gi-1];
        end

        assign trial = (DW'(q_in) << (K + 1)) + (DW'(1) << (2 * K));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_reg[gi] <= '0;
            else
                sq_reg[gi] <= sd_in;
        end

        always_ff @(posedge clk)
        begin
            if (rem_in >= trial)
            begin
                rem_reg[gi] <= rem_in - trial;
                q_reg[gi]   <= q_in | (RW'(1) << K);
            end
            else
            begin
                rem_reg[gi] <= rem_in;
                q_reg[gi]   <= q_in;
            end
        end
    end

    // root selection
    side_t              sq_last, sn_c, sn_reg;
    logic signed [NSW-1:0] n1, n2, a_ext;
    logic               c1, c2;
    logic [SW-1:0]      n_reg;
    logic [VW-1:0]      vabs_reg [3];

    assign sq_last = sq_reg[RW-1];

    always_comb
    begin
        a_ext = $signed({2'b00, sq_last.a});
        n1    = -NSW'($signed(sq_last.h)) + $signed({2'b00, q_reg[RW-1]});
        n2    = -NSW'($signed(sq_last.h)) - $signed({2'b00, q_reg[RW-1]});
        c1    = !n1[NSW-1] && (n1 <= a_ext);
        c2    = !n2[NSW-1] && (n2 <= a_ext);
        sn_c    = sq_last;
        sn_c.ok = sq_last.ok && (c1 || c2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sn_reg <= '0;
        else
            sn_reg <= sn_c;
    end

    always_ff @(posedge clk)
    begin
        n_reg <= c1 ? $unsigned(n1[SW-1:0]) : $unsigned(n2[SW-1:0]);
        for (int i = 0; i < 3; i++)
        begin
            vabs_reg[i] <= sq_last.v[i][VW-1] ? -sq_last.v[i] : sq_last.v[i];
        end
    end

    // numerators n * |v|
    logic signed [NW-1:0] prod [3];

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_num
        ssi_mul #(.AW(SW + 1), .BW(VW + 1)) u_nv (
            .clk (clk),
            .a   ($signed({1'b0, n_reg})),
            .b   ($signed({1'b0, vabs_reg[gi]})),
            .p   (prod[gi])
        );
    end

    side_t sm1_reg, sm2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm1_reg <= '0;
            sm2_reg <= '0;
        end
        else
        begin
            sm1_reg <= sn_reg;
            sm2_reg <= sm1_reg;
        end
    end

    // restoring divide by a, one quotient bit per stage
    side_t         sd_reg  [QB];
    logic [NW-1:0] num_reg [3][QB];
    logic [QB-1:0] quo_reg [3][QB];

    for (genvar gj = 0; gj < QB; gj++)
    begin : g_div
        localparam int K = QB - 1 - gj;
        side_t sd_in;

        if (gj == 0)
        begin : g_first
            assign sd_in = sm2_reg;
        end
        else
        begin : g_next
            assign sd_in = sd_reg[gj-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sd_reg[gj] <= '0;
            else
                sd_reg[gj] <= sd_in;
        end

        for (genvar gx = 0; gx < 3; gx++)
        begin : g_axis
            logic [NW-1:0] nin, dvs;
            logic [QB-1:0] qin;

            if (gj == 0)
            begin : g_first
                assign nin = $unsigned(prod[gx]);
                assign qin = '0;
            end
            else
            begin : g_next
                assign nin = num_reg[gx][gj-1];
                assign qin = quo_reg[gx][gj-1];
            end

            assign dvs = NW'(sd_in.a) << K;

            always_ff @(posedge clk)
            begin
                if (nin >= dvs)
                begin
                    num_reg[gx][gj] <= nin - dvs;
                    quo_reg[gx][gj] <= qin | (QB'(1) << K);
                end
                else
                begin
                    num_reg[gx][gj] <= nin;
                    quo_reg[gx][gj] <= qin;
                end
            end
        end
    end

    // output register
    side_t          sd_last;
    logic [W-1:0]   coord [3];
    logic           done_reg, hit_reg, inside_reg;
    logic [W-1:0]   hx_reg, hy_reg, hz_reg;

    assign sd_last = sd_reg[QB-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!sd_last.ok)
                coord[i] = '0;
            else if (sd_last.v[i][VW-1])
                coord[i] = sd_last.s[i] - W'(quo_reg[i][QB-1]);
            else
                coord[i] = sd_last.s[i] + W'(quo_reg[i][QB-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sd_last.vld;
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= sd_last.ok;
        inside_reg <= sd_last.in_sph;
        hx_reg     <= coord[0];
        hy_reg     <= coord[1];
        hz_reg     <= coord[2];
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign start_inside = inside_reg;
    assign hit_x        = $signed(hx_reg);
    assign hit_y        = $signed(hy_reg);
    assign hit_z        = $signed(hz_reg);

endmodule

### rtl/core/ssi_mul.sv
module ssi_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                  clk,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AW-1:0] ma;
    logic [BW-1:0] mb;
    logic [AL+BL-1:0] pll_reg;
    logic [AL+BH-1:0] plh_reg;
    logic [AH+BL-1:0] phl_reg;
    logic [AH+BH-1:0] phh_reg;
    logic             neg_reg;
    logic [PW-1:0]    sum;
    logic signed [PW-1:0] p_reg;

    // magnitudes, split into halves for the partial products
    assign ma = a[AW-1] ? $unsigned(-a) : $unsigned(a);
    assign mb = b[BW-1] ? $unsigned(-b) : $unsigned(b);

    always_ff @(posedge clk)
    begin
        pll_reg <= ma[AL-1:0] * mb[BL-1:0];
        plh_reg <= ma[AL-1:0] * mb[BW-1:BL];
        phl_reg <= ma[AW-1:AL] * mb[BL-1:0];
        phh_reg <= ma[AW-1:AL] * mb[BW-1:BL];
        neg_reg <= a[AW-1] ^ b[BW-1];
    end

    assign sum = PW'(pll_reg)
               + (PW'(plh_reg) << BL)
               + (PW'(phl_reg) << AL)
               + (PW'(phh_reg) << (AL + BL));

    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg ? $signed(-sum) : $signed(sum);
    end

    assign p = p_reg;

endmodule

### bench/segment_sphere_intersection_checker.sv
`timescale 1ns / 100ps

module segment_sphere_intersection_checker
    import ssi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic               done,
    input  logic               hit,
    input  logic signed [31:0] hit_x,
    input  logic signed [31:0] hit_y,
    input  logic signed [31:0] hit_z,
    input  logic               start_inside,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    typedef logic signed [159:0] wide_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        in_sph;
    } hit_result_t;

    logic signed [31:0] sph_cx, sph_cy, sph_cz;
    logic [30:0]        sph_r;
    hit_result_t        expected_hits[$];

    function automatic wide_t floor_sqrt(input wide_t n);
        wide_t root;
        wide_t trial;
        root = 0;
        for (int b = 79; b >= 0; b--) begin
            trial = root | (wide_t'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [31:0] point_on_segment(input wide_t s, input wide_t v,
                                                     input wide_t n, input wide_t a);
        wide_t mag;
        wide_t q;
        mag = (v < 0) ? -v : v;
        q = (n * mag) / a;
        return 32'(s + ((v < 0) ? -q : q));
    endfunction

    function automatic hit_result_t intersect_sphere(input logic signed [31:0] sx,
        input logic signed [31:0] sy, input logic signed [31:0] sz,
        input logic signed [31:0] ex, input logic signed [31:0] ey,
        input logic signed [31:0] ez);
        hit_result_t res;
        wide_t vx, vy, vz, dx, dy, dz, a, h, dd, r2, disc, root, n1, n2, n;
        res = '0;
        vx = wide_t'(ex) - wide_t'(sx);
        vy = wide_t'(ey) - wide_t'(sy);
        vz = wide_t'(ez) - wide_t'(sz);
        dx = wide_t'(sx) - wide_t'(sph_cx);
        dy = wide_t'(sy) - wide_t'(sph_cy);
        dz = wide_t'(sz) - wide_t'(sph_cz);
        a = vx * vx + vy * vy + vz * vz;
        h = vx * dx + vy * dy + vz * dz;
        dd = dx * dx + dy * dy + dz * dz;
        r2 = wide_t'({1'b0, sph_r}) * wide_t'({1'b0, sph_r});
        res.in_sph = dd < r2;
        if (a != 0) begin
            disc = h * h - a * (dd - r2);
            if (disc >= 0) begin
                root = floor_sqrt(disc);
                n1 = -h + root;
                n2 = -h - root;
                n = 0;
                if (n1 >= 0 && n1 <= a) begin
                    n = n1;
                    res.hit = 1'b1;
                end else if (n2 >= 0 && n2 <= a) begin
                    n = n2;
                    res.hit = 1'b1;
                end
                if (res.hit) begin
                    res.x = point_on_segment(wide_t'(sx), vx, n, a);
                    res.y = point_on_segment(wide_t'(sy), vy, n, a);
                    res.z = point_on_segment(wide_t'(sz), vz, n, a);
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t exp_r;
        if (!rst_n) begin
            sph_cx = 0;
            sph_cy = 0;
            sph_cz = 0;
            sph_r = 31'(RADIUS_RESET);
            expected_hits.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CENTER_X: sph_cx = cfg_data;
                    CFG_CENTER_Y: sph_cy = cfg_data;
                    CFG_CENTER_Z: sph_cz = cfg_data;
                    CFG_RADIUS:   sph_r = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_hits.push_back(intersect_sphere(start_x, start_y, start_z,
                                                         end_x, end_y, end_z));
            if (done) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t unexpected result transfer", $time);
                    fail_count++;
                end else begin
                    exp_r = expected_hits.pop_front();
                    if (exp_r != {hit, hit_x, hit_y, hit_z, start_inside}) begin
                        $display("%0t mismatch exp hit=%0d x=%h y=%h z=%h in=%0d",
                                 $time, exp_r.hit, exp_r.x, exp_r.y, exp_r.z, exp_r.in_sph);
                        $display("%0t          act hit=%0d x=%h y=%h z=%h in=%0d",
                                 $time, hit, hit_x, hit_y, hit_z, start_inside);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_hits.size();
    end

endmodule

### bench/segment_sphere_intersection_tb.sv
`timescale 1ns / 100ps

module segment_sphere_intersection_tb;
    import ssi_pkg::*;

    localparam int LATENCY = 113;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic done, hit, start_inside;
    logic signed [31:0] hit_x, hit_y, hit_z;
    logic cfg_valid, cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [31:0] cfg_data;
    int fail_count;
    int pending;
    int idle_cycles;

    segment_sphere_intersection u_dut (.*);

    segment_sphere_intersection_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] random_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            default: return 32'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    task automatic write_sphere_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] r);
        write_sphere_reg(CFG_CENTER_X, cx);
        write_sphere_reg(CFG_CENTER_Y, cy);
        write_sphere_reg(CFG_CENTER_Z, cz);
        write_sphere_reg(CFG_RADIUS, r);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_segment(input logic [31:0] sx, input logic [31:0] sy,
                                input logic [31:0] sz, input logic [31:0] ex,
                                input logic [31:0] ey, input logic [31:0] ez);
        start <= 1'b1;
        start_x <= sx;
        start_y <= sy;
        start_z <= sz;
        end_x <= ex;
        end_y <= ey;
        end_z <= ez;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic random_phase(input int count, input int mode);
        logic [31:0] sx, sy, sz;
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                sx = random_coord(mode);
                sy = random_coord(mode);
                sz = random_coord(mode);
                case ($urandom_range(0, 9))
                    0: send_segment(sx, sy, sz, sx, sy, sz);
                    1: send_segment(sx, sy, sz, -sx, -sy, -sz);
                    default: send_segment(sx, sy, sz, random_coord(mode),
                                          random_coord(mode), random_coord(mode));
                endcase
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        start_x = 0;
        start_y = 0;
        start_z = 0;
        end_x = 0;
        end_y = 0;
        end_z = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CENTER_X;
        cfg_data = 0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset sphere: radius 65536 at origin
        send_segment(-32'sd131072, 0, 0, 32'sd131072, 0, 0);
        send_segment(0, 0, 0, 32'sd131072, 0, 0);
        send_segment(5, 5, 5, 5, 5, 5);
        send_segment(-32'sd131072, 32'sd65536, 0, 32'sd131072, 32'sd65536, 0);
        send_segment(-32'sd131072, 32'sd131072, 0, 32'sd131072, 32'sd131072, 0);
        send_segment(32'sd131072, 0, 0, 32'sd262144, 0, 0);
        send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h80000000);
        send_segment(32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_segment(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0);
        send_segment(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
        send_segment(0, 32'sd65536, 0, 0, 32'sd65535, 0);
        drain();

        set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_segment(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_segment(32'h80000000, 32'h7fffffff, 32'h80000000,
                     32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_segment(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 2, 3);
        drain();

        set_sphere(0, 0, 0, 0);
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(-5, 0, 0, 5, 0, 0);
        send_segment(-5, 1, 0, 5, 1, 0);
        drain();

        set_sphere(32'sd65536, -32'sd65536, 32'sd32768, 32'sd196608);
        random_phase(500, 1);
        drain();

        set_sphere(32'($signed($urandom_range(0, 4000)) - 2000),
                   32'($signed($urandom_range(0, 4000)) - 2000),
                   32'($signed($urandom_range(0, 4000)) - 2000), $urandom_range(1, 3000));
        random_phase(500, 2);
        drain();

        set_sphere($urandom(), $urandom(), $urandom(), {1'b0, $urandom()} >> 1);
        random_phase(350, 0);
        drain();

        set_sphere(0, 0, 0, 32'h7fffffff);
        random_phase(350, 0);
        drain();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
